/* rtl/core/lfvc_pkg.sv */
package lfvc_pkg;

  typedef enum logic [2:0] {
    MODE_BOOT      = 3'd0,
    MODE_BOOT_ALM  = 3'd1,
    MODE_READY     = 3'd2,
    MODE_READY_ALM = 3'd3,
    MODE_RUN_WAIT  = 3'd4,
    MODE_RUN       = 3'd5,
    MODE_STOP_WAIT = 3'd6,
    MODE_RUN_ALM   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FIN  = 2'd2
  } ctrl_state_e;

  // Input transaction layout.
  localparam int unsigned InDataW     = 24;
  localparam int unsigned InSensorLsb = 0;
  localparam int unsigned InRunLsb    = 8;
  localparam int unsigned InMotorLsb  = 9;
  localparam int unsigned InAngleLsb  = 10;

  // Output transaction layout.
  localparam int unsigned OutDataW    = 24;
  localparam int unsigned OutPadW     = 2;

  localparam int unsigned NumSensors  = 8;
  localparam int unsigned DivSteps    = 8;
  localparam int unsigned StepCntW    = 3;
  localparam logic [7:0]  CenterReset = 8'd128;

  localparam logic [7:0] PosWeight [NumSensors] = '{
    8'd16, 8'd48, 8'd80, 8'd112, 8'd144, 8'd176, 8'd208, 8'd240
  };

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/line_follow_vehicle_controller_unit.sv */
// Line-follow vehicle controller, one result transaction per control tick.
// Input stream (s_axis): one transaction per tick carrying the line sensor
// bits, the run switch, the motor-running flag and the measured steering
// angle. Output stream (m_axis): vehicle mode, line position, steering drive,
// drive valid flag and the motor-timer and alarm-resume pulses.
// Configuration: cfg_we_i writes cfg_wdata_i into the steering center
// register; write it only while no tick is in flight.
// Timing: an input transaction is accepted only while the block is idle, and the next
// input is not taken until the result of the previous one has gone to the output register.
// The result is formed by the restoring divider that works out the centroid,
// one quotient bit per cycle, eight bits in all.
// Reset puts the vehicle in boot mode, sets the steering center to 128 and
// empties the output register.
// When the receiver stalls, the result holds in the output register and the
// block still takes and works on the next input; it then waits with that
// result finished until the output register is free.
module line_follow_vehicle_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sensor_bits[7:0], run_switch[8], motor_running[9], steer_angle[17:10]
  input  logic [lfvc_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // vehicle_mode[2:0], line_position[10:3], drive_value[18:11], drive_valid[19],
  // start_motor_timer[20], resumed_from_alarm[21]
  output logic [lfvc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import lfvc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .sts_i      (sts),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  lfvc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .sts_o       (sts)
  );

endmodule

/* rtl/core/lfvc_ctrl.sv */
module lfvc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  lfvc_pkg::sts_t sts_i,
  output logic          s_tready_o,
  output lfvc_pkg::cmd_t cmd_o
);
  import lfvc_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [StepCntW-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == StepCntW'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here until the output register can take the new result.
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/lfvc_dp.sv */
module lfvc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfvc_pkg::cmd_t                cmd_i,
  input  logic [lfvc_pkg::InDataW-1:0]  in_data_i,
  input  logic                          cfg_we_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [lfvc_pkg::OutDataW-1:0] out_data_o,
  output lfvc_pkg::sts_t                sts_o
);
  import lfvc_pkg::*;

  logic [7:0] sensor;
  logic       run_sw;
  logic       motor;
  logic       any_set;

  logic [7:0] center_q;
  mode_e      mode_q, mode_d;
  logic       timer_pulse, resume_pulse;
  logic       timer_q, resume_q;
  logic [7:0] angle_q;

  logic [10:0] wsum;
  logic [3:0]  bit_cnt;
  logic [3:0]  cnt_q;
  logic [3:0]  rem_q, rem_d;
  logic [7:0]  quo_q, quo_d;
  logic [4:0]  trial;

  logic [7:0]         pos;
  logic signed [9:0]  diff;
  logic signed [14:0] prod;
  logic signed [14:0] prod_adj;
  logic signed [9:0]  corr;
  logic signed [11:0] sum_v;
  logic [7:0]         sat_v;
  logic [7:0]         drive;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign sensor  = in_data_i[InSensorLsb +: 8];
  assign run_sw  = in_data_i[InRunLsb];
  assign motor   = in_data_i[InMotorLsb];
  assign any_set = |sensor;

  // Vehicle mode update for the incoming tick.
  always_comb begin
    mode_d       = mode_q;
    timer_pulse  = 1'b0;
    resume_pulse = 1'b0;
    unique case (mode_q)
      MODE_BOOT, MODE_BOOT_ALM: begin
        mode_d = (any_set && !run_sw) ? MODE_READY : MODE_BOOT_ALM;
      end
      MODE_READY: begin
        if (run_sw) begin
          mode_d      = MODE_RUN_WAIT;
          timer_pulse = 1'b1;
        end else if (!any_set) begin
          mode_d = MODE_READY_ALM;
        end
      end
      MODE_READY_ALM: begin
        if (any_set && !run_sw) mode_d = MODE_READY;
      end
      MODE_RUN_WAIT: begin
        if (motor) mode_d = MODE_RUN;
      end
      MODE_RUN: begin
        if (!run_sw) begin
          mode_d = MODE_STOP_WAIT;
        end else if (!any_set) begin
          mode_d = MODE_RUN_ALM;
        end
      end
      MODE_STOP_WAIT: begin
        if (!motor) begin
          mode_d = MODE_READY;
        end else if (!any_set) begin
          mode_d = MODE_RUN_ALM;
        end
      end
      MODE_RUN_ALM: begin
        if (any_set && run_sw) begin
          if (motor) begin
            mode_d       = MODE_RUN;
            resume_pulse = 1'b1;
          end else begin
            mode_d = MODE_READY;
          end
        end
      end
      default: mode_d = MODE_BOOT;
    endcase
  end

  // Weighted sum and count of the set sensor bits.
  always_comb begin
    wsum    = '0;
    bit_cnt = '0;
    for (int i = 0; i < NumSensors; i++) begin
      if (sensor[i]) begin
        wsum    = wsum + 11'(PosWeight[i]);
        bit_cnt = bit_cnt + 4'd1;
      end
    end
  end

  // One quotient bit per step. The quotient stays below 256, so the top three
  // bits of the sum can seed the partial remainder.
  always_comb begin
    trial = {rem_q, quo_q[7]};
    if (trial >= {1'b0, cnt_q}) begin
      rem_d = 4'(trial - {1'b0, cnt_q});
      quo_d = {quo_q[6:0], 1'b1};
    end else begin
      rem_d = trial[3:0];
      quo_d = {quo_q[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BOOT;
      center_q <= CenterReset;
    end else begin
      if (cfg_we_i) center_q <= cfg_wdata_i;
      if (cmd_i.load) mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      timer_q  <= timer_pulse;
      resume_q <= resume_pulse;
      angle_q  <= in_data_i[InAngleLsb +: 8];
      cnt_q    <= bit_cnt;
      rem_q    <= {1'b0, wsum[10:8]};
      quo_q    <= wsum[7:0];
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Steering drive: angle + (pos - center) * 17 / 32 truncated toward zero, clamped to 0..255; zero outside run.
  always_comb begin
    pos      = (cnt_q == 4'd0) ? 8'd0 : quo_q;
    diff     = $signed({2'b00, pos}) - $signed({2'b00, center_q});
    prod     = (15'(diff) <<< 4) + 15'(diff);
    prod_adj = prod + ((prod < 0) ? 15'sd31 : 15'sd0);
    corr     = 10'(prod_adj >>> 5);
    sum_v    = 12'(corr) + $signed({4'b0000, angle_q});
    if (sum_v < 0) begin
      sat_v = 8'd0;
    end else if (sum_v > 12'sd255) begin
      sat_v = 8'd255;
    end else begin
      sat_v = sum_v[7:0];
    end
    drive = (mode_q == MODE_RUN) ? sat_v : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {{OutPadW{1'b0}}, resume_q, timer_q, (mode_q == MODE_RUN),
                     drive, pos, mode_q};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

/* rtl/core/lfvc_checker.sv */
module lfvc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [lfvc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);
  import lfvc_pkg::*;

  // A stalled result must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  // The drive is flagged valid exactly in run mode, and is zero otherwise.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[19] == (m_axis_tdata[2:0] == MODE_RUN)) &&
                      (m_axis_tdata[19] || (m_axis_tdata[18:11] == 8'd0)))
    else $error("drive valid flag disagrees with mode");

  // The motor timer pulse only comes with the step into run wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[2:0] == MODE_RUN_WAIT)
    else $error("timer pulse outside run wait");

  // Leaving the run alarm by resuming always lands in run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[2:0] == MODE_RUN)
    else $error("resume pulse outside run");

  // Once an input is accepted the block is busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a tick is in progress");

endmodule

bind line_follow_vehicle_controller_unit lfvc_checker u_lfvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

/* dv/line_follow_vehicle_controller_unit_tb.sv */
import lfvc_pkg::*;

// Low bits of s_axis_tdata: sensor_bits lowest, then run, motor, angle.
typedef struct packed {
  logic [7:0] angle;
  logic       motor;
  logic       run;
  logic [7:0] sensor;
} tick_t;

// Low bits of m_axis_tdata, vehicle_mode lowest.
typedef struct packed {
  logic       resumed;
  logic       timer_start;
  logic       drive_ok;
  logic [7:0] drive;
  logic [7:0] position;
  mode_e      mode;
} ctrl_result_t;

class lfvc_scoreboard;
  mode_e        mode;
  logic [7:0]   center;
  ctrl_result_t pending_results[$];
  int unsigned  errors;

  function new();
    mode   = MODE_BOOT;
    center = CenterReset;
    errors = 0;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  function logic [7:0] centroid(logic [7:0] bits);
    int unsigned sum;
    int unsigned cnt;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        sum += 16 + 32 * i;
        cnt++;
      end
    end
    if (cnt == 0) return 8'd0;
    return 8'(sum / cnt);
  endfunction

  // SystemVerilog integer division truncates toward zero, as the block must.
  function logic [7:0] steer_drive(logic [7:0] pos, logic [7:0] angle);
    int p;
    int c;
    int a;
    int v;
    p = pos;
    c = center;
    a = angle;
    v = ((p - c) * 17) / 32 + a;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function void accept_tick(tick_t t);
    ctrl_result_t r;
    mode_e        nxt;
    logic         s;
    s   = |t.sensor;
    nxt = mode;
    r   = '0;
    case (mode)
      MODE_BOOT, MODE_BOOT_ALM: begin
        nxt = (s && !t.run) ? MODE_READY : MODE_BOOT_ALM;
      end
      MODE_READY: begin
        if (t.run) begin
          nxt = MODE_RUN_WAIT;
          r.timer_start = 1'b1;
        end else if (!s) begin
          nxt = MODE_READY_ALM;
        end
      end
      MODE_READY_ALM: begin
        if (s && !t.run) nxt = MODE_READY;
      end
      MODE_RUN_WAIT: begin
        if (t.motor) nxt = MODE_RUN;
      end
      MODE_RUN: begin
        if (!t.run) nxt = MODE_STOP_WAIT;
        else if (!s) nxt = MODE_RUN_ALM;
      end
      MODE_STOP_WAIT: begin
        if (!t.motor) nxt = MODE_READY;
        else if (!s) nxt = MODE_RUN_ALM;
      end
      default: begin
        if (s && t.run) begin
          if (t.motor) begin
            nxt = MODE_RUN;
            r.resumed = 1'b1;
          end else begin
            nxt = MODE_READY;
          end
        end
      end
    endcase
    mode       = nxt;
    r.mode     = nxt;
    r.position = centroid(t.sensor);
    if (nxt == MODE_RUN) begin
      r.drive    = steer_drive(r.position, t.angle);
      r.drive_ok = 1'b1;
    end
    pending_results.push_back(r);
  endfunction

  task report(string field, int unsigned want, int unsigned got);
    errors++;
    // Keep the log readable when the block is badly broken.
    if (errors <= 40) $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  task check_result(logic [OutDataW-1:0] data);
    ctrl_result_t got;
    ctrl_result_t want;
    got = data[$bits(ctrl_result_t)-1:0];
    if (pending_results.size() == 0) begin
      report("unexpected result transaction", 0, data);
      return;
    end
    want = pending_results.pop_front();
    if (got.mode != want.mode) report("vehicle_mode", want.mode, got.mode);
    if (got.position != want.position) report("line_position", want.position, got.position);
    if (got.drive != want.drive) report("drive_value", want.drive, got.drive);
    if (got.drive_ok != want.drive_ok) report("drive_valid", want.drive_ok, got.drive_ok);
    if (got.timer_start != want.timer_start) begin
      report("start_motor_timer", want.timer_start, got.timer_start);
    end
    if (got.resumed != want.resumed) report("resumed_from_alarm", want.resumed, got.resumed);
  endtask
endclass

module line_follow_vehicle_controller_unit_tb;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_profile_e;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseTicks   = 87;

  logic                clk_i;
  logic                rst_ni;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_we_i;
  logic [7:0]          cfg_wdata_i;

  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    cycle_cnt;
  logic           run_sw;
  logic           motor_on;
  lfvc_scoreboard tick_board;

  line_follow_vehicle_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("line_follow_vehicle_controller_unit_tb: done, errors");
      $finish;
    end else begin
      if (m_axis_tvalid && m_axis_tready) tick_board.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic tick_t make_tick(logic [7:0] sensor, logic run, logic motor,
                                      logic [7:0] angle);
    tick_t t;
    t.sensor = sensor;
    t.run    = run;
    t.motor  = motor;
    t.angle  = angle;
    return t;
  endfunction

  // Switches mostly hold their state so the mode machine walks through whole
  // run cycles; a share of fully random ticks is mixed in as noise.
  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned pick;
    t = tick_t'(18'($urandom));
    if ($urandom_range(0, 99) < 10) return t;
    if ($urandom_range(0, 99) < 15) run_sw = ~run_sw;
    if ($urandom_range(0, 99) < 20) motor_on = ~motor_on;
    t.run   = run_sw;
    t.motor = motor_on;
    pick = $urandom_range(0, 99);
    if (pick < 15) t.sensor = 8'h00;
    else if (pick < 40) t.sensor = 8'(1 << $urandom_range(0, 7));
    else if (pick < 65) t.sensor = 8'(3 << $urandom_range(0, 7));
    else t.sensor = 8'($urandom_range(1, 255));
    pick = $urandom_range(0, 99);
    if (pick < 10) t.angle = 8'd0;
    else if (pick < 20) t.angle = 8'd255;
    return t;
  endfunction

  task automatic set_idling(idle_profile_e profile);
    send_idle_pct  = (profile == IDLE_SEND) ? 51 : (profile == IDLE_BOTH) ? 36 : 0;
    recv_stall_pct = (profile == IDLE_RECV) ? 51 : (profile == IDLE_BOTH) ? 36 : 0;
  endtask

  task automatic send_tick(tick_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - $bits(tick_t)){1'b0}}, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tick_board.accept_tick(t);
  endtask

  // Hold the sender until every expected result is back and the block has
  // had time to go quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tick_board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_center(logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tick_board.center = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] centers [PhaseCount];
    logic [7:0] center;
    centers = '{8'd0, 8'd255, 8'd0, 8'd77, 8'd128, 8'd1, 8'd254, 8'd0};
    tick_board     = new();
    run_sw         = 1'b0;
    motor_on       = 1'b0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    m_axis_tready  <= 1'b1;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk through every mode with the reset center, including the
    // drive clamping at both ends and ticks with no sensor bit set.
    set_idling(IDLE_NONE);
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 8'd0));
    send_tick(make_tick(8'hff, 1'b1, 1'b1, 8'd255));
    send_tick(make_tick(8'h01, 1'b0, 1'b0, 8'd10));
    send_tick(make_tick(8'h00, 1'b0, 1'b1, 8'd20));
    send_tick(make_tick(8'h80, 1'b1, 1'b0, 8'd30));
    send_tick(make_tick(8'h80, 1'b0, 1'b0, 8'd40));
    send_tick(make_tick(8'h18, 1'b1, 1'b0, 8'd50));
    send_tick(make_tick(8'h18, 1'b1, 1'b0, 8'd60));
    send_tick(make_tick(8'h01, 1'b1, 1'b1, 8'd0));
    send_tick(make_tick(8'h80, 1'b1, 1'b1, 8'd255));
    send_tick(make_tick(8'hff, 1'b1, 1'b0, 8'd128));
    send_tick(make_tick(8'h00, 1'b1, 1'b1, 8'd200));
    send_tick(make_tick(8'h3c, 1'b1, 1'b1, 8'd100));
    send_tick(make_tick(8'h81, 1'b0, 1'b1, 8'd100));
    send_tick(make_tick(8'h00, 1'b0, 1'b1, 8'd5));
    send_tick(make_tick(8'h02, 1'b1, 1'b0, 8'd5));
    send_tick(make_tick(8'h40, 1'b1, 1'b0, 8'd250));
    send_tick(make_tick(8'h40, 1'b1, 1'b1, 8'd250));
    send_tick(make_tick(8'haa, 1'b0, 1'b1, 8'd1));
    send_tick(make_tick(8'h55, 1'b0, 1'b0, 8'd254));
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      center = (p == 2 || p == 7) ? 8'($urandom_range(0, 255)) : centers[p];
      write_center(center);
      set_idling(idle_profile_e'(p % 4));
      for (int n = 0; n < PhaseTicks; n++) begin
        if (p == 5 && n == PhaseTicks / 2) drain();
        send_tick(random_tick());
      end
      drain();
    end

    if (tick_board.errors == 0) begin
      $display("line_follow_vehicle_controller_unit_tb: done, clean");
    end else begin
      $display("line_follow_vehicle_controller_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
